@@ hw/rtl/spwm_compare_generator_top_macros.svh @@
// assertion macros for the sinusoidal pwm compare generator
// used by spwm_compare_generator_top, no other dependencies
`ifndef SPWM_COMPARE_GENERATOR_TOP_MACROS_SVH
`define SPWM_COMPARE_GENERATOR_TOP_MACROS_SVH

// same-cycle implication, reset masks the check
`define SPWMCG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("spwmcg assertion failed");

// next-cycle implication, reset masks the check
`define SPWMCG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("spwmcg assertion failed");

`endif

@@ hw/rtl/spwmcg_pkg.sv @@
// types and constants of the sinusoidal pwm compare generator
// no dependencies, used by spwm_compare_generator_top and spwmcg_seq
`default_nettype none

package spwmcg_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 2'd3;

    localparam logic [31:0] RST_PHASE_STEP = 32'd0;
    localparam logic [15:0] RST_MOD_DEPTH  = 16'd32768;
    localparam logic [15:0] RST_PERIOD     = 16'd65535;
    localparam logic        RST_TARGET     = 1'b0;

    // command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // odd sine polynomial, q30
    localparam logic [31:0] COEF_A1 = 32'd1686629713;
    localparam logic [31:0] COEF_A3 = 32'd693598668;
    localparam logic [31:0] COEF_A5 = 32'd85569306;
    localparam logic [31:0] COEF_A7 = 32'd5026995;
    localparam logic [31:0] COEF_A9 = 32'd172272;

    localparam logic [16:0] MAG_MAX    = 17'd65536;
    localparam logic [32:0] MAG_ROUND  = 33'd8192;
    localparam logic [21:0] TERM_MID   = 22'd1310720;  // 20 * 65536
    localparam logic [21:0] SINE_GAIN  = 22'd19;
    // ceil(2^21 / 5), exact floor(n / 5) for n below 2^19
    localparam logic [31:0] DIV5_RECIP = 32'd419431;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    // one step of the shared multiplier per cycle, holding on the last step while the output is stalled
    typedef enum logic [3:0] {
        OP_SQ,   // x * x
        OP_T9,   // x2 * a9
        OP_T7,   // x2 * (a7 - ..)
        OP_T5,   // x2 * (a5 - ..)
        OP_T3,   // x2 * (a3 - ..)
        OP_T1,   // x * (a1 - ..)
        OP_DP,   // depth * period, sine to term
        OP_TM,   // (depth * period) * term
        OP_DV,   // scaled product / 5 by reciprocal
        OP_OUT   // result to output register
    } t_op;

    typedef struct packed {
        t_op  op;
        logic run;
        logic ready;
    } t_seq_ctl;

endpackage

`default_nettype wire

@@ hw/rtl/spwm_compare_generator_top.sv @@
// top level of the sinusoidal pwm compare generator: registers, phase, datapath
// depends on spwmcg_pkg, spwmcg_mul, spwmcg_seq and the macro header
//
//  channel   direction  tdata                    tuser
//  s_axis    in         [31:0] new_phase         [0] command (0 tick, 1 load)
//  m_axis    out        [15:0] compare_value     [0] compare_target
//  i_cfg_*   in         write enable, 2-bit index, 32-bit data, no read-back
//
//  one word goes from accept to output word through the accept cycle, then nine
//  steps of the single 32 x 32 multiplier (polynomial, scaling, divide by five) and
//  one step that loads the output register; no new word is taken until that load
//  a finished word waits in the output register; the sequencer holds on its last
//  step while that register is full and stalled, with the multiplier frozen
//  reset is synchronous, active low, and needs no clearing pass
`default_nettype none
`include "spwm_compare_generator_top_macros.svh"

module spwm_compare_generator_top #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration writes
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [spwmcg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [spwmcg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input words
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [31:0]                       s_axis_tdata,  // [31:0] new_phase
    input  wire logic                              s_axis_tuser,  // [0] command
    // output words
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [15:0]                       m_axis_tdata,  // [15:0] compare_value
    output logic                                   m_axis_tuser   // [0] compare_target
);

    // phase words wider or narrower than 32 bits are zero-extended then cut to one turn
    localparam int EXT_W = (PHASE_BITS > 32) ? PHASE_BITS : 32;
    localparam int QB    = SINE_TABLE_BITS - 2;   // bits of position within a quarter
    localparam int XSH   = 30 - QB;               // position to q30

    // configuration registers
    logic [31:0] r_phase_step;
    logic [15:0] r_depth;
    logic [15:0] r_period;
    logic        r_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= spwmcg_pkg::RST_PHASE_STEP;
            r_depth      <= spwmcg_pkg::RST_MOD_DEPTH;
            r_period     <= spwmcg_pkg::RST_PERIOD;
            r_target     <= spwmcg_pkg::RST_TARGET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                spwmcg_pkg::REG_PHASE_STEP: r_phase_step <= i_cfg_data;
                spwmcg_pkg::REG_MOD_DEPTH:  r_depth      <= i_cfg_data[15:0];
                spwmcg_pkg::REG_PERIOD:     r_period     <= i_cfg_data[15:0];
                spwmcg_pkg::REG_TARGET:     r_target     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    spwmcg_pkg::t_seq_ctl w_ctl;
    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_mul_en;

    assign s_axis_tready = w_ctl.ready;
    assign w_in_acc      = s_axis_tvalid && w_ctl.ready;
    assign w_out_free    = !m_axis_tvalid || m_axis_tready;
    // the last step only reads the product, so a stall there keeps it intact
    assign w_mul_en      = w_ctl.run && (w_ctl.op != spwmcg_pkg::OP_OUT);

    spwmcg_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl)
    );

    // phase accumulator
    logic [PHASE_BITS-1:0] r_phase;
    logic [EXT_W-1:0]      w_new_ext;
    logic [EXT_W-1:0]      w_step_ext;
    logic [PHASE_BITS-1:0] w_new_phase;
    logic [PHASE_BITS-1:0] w_step;
    logic [PHASE_BITS-1:0] w_phase_sel;

    assign w_new_ext   = EXT_W'(s_axis_tdata);
    assign w_step_ext  = EXT_W'(r_phase_step);
    assign w_new_phase = w_new_ext[PHASE_BITS-1:0];
    assign w_step      = w_step_ext[PHASE_BITS-1:0];
    // a load uses the new phase, a tick the phase before advancing
    assign w_phase_sel = (s_axis_tuser == spwmcg_pkg::CMD_LOAD) ? w_new_phase : r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_in_acc) begin
            if (s_axis_tuser == spwmcg_pkg::CMD_LOAD) begin
                r_phase <= w_new_phase;
            end else begin
                r_phase <= r_phase + w_step;
            end
        end
    end

    // table index: top bits of the phase, folded onto the first quarter
    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [QB:0]                w_pos_raw;
    logic [QB:0]                w_pos;
    logic [QB:0]                w_qsize;
    logic [30:0]                w_x;

    assign w_idx     = w_phase_sel[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign w_qsize   = {1'b1, {QB{1'b0}}};
    assign w_pos_raw = {1'b0, w_idx[QB-1:0]};
    // second and fourth quarters run backward
    assign w_pos     = w_idx[QB] ? (w_qsize - w_pos_raw) : w_pos_raw;
    assign w_x       = 31'(w_pos) << XSH;

    // operands that live across steps
    logic [30:0] r_x;      // q30 position within the quarter
    logic        r_neg;    // lower half-turn
    logic [31:0] r_x2;     // q30 x squared
    logic [21:0] r_term;   // 20 * 65536 + 19 * signed sine

    // shared multiplier
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;

    spwmcg_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    logic [31:0] w_q30;       // previous product back to q30
    logic [32:0] w_rnd;
    logic [18:0] w_mag_raw;
    logic [16:0] w_mag;
    logic [21:0] w_sine19;
    logic [21:0] w_term;
    logic [31:0] w_div_in;    // floor(prod / 2^35)
    logic [15:0] w_result;

    assign w_q30     = w_prod[61:30];
    // magnitude rounded half up to q16 and clamped to one
    assign w_rnd     = {1'b0, w_q30} + spwmcg_pkg::MAG_ROUND;
    assign w_mag_raw = w_rnd[32:14];
    assign w_mag     = (w_mag_raw > 19'(spwmcg_pkg::MAG_MAX)) ? spwmcg_pkg::MAG_MAX
                                                              : w_mag_raw[16:0];
    assign w_sine19  = 22'(w_mag) * spwmcg_pkg::SINE_GAIN;
    assign w_term    = r_neg ? (spwmcg_pkg::TERM_MID - w_sine19)
                             : (spwmcg_pkg::TERM_MID + w_sine19);
    // divide by 40 * 2^32: shift by 35, then divide by five
    assign w_div_in  = 32'(w_prod[53:35]);
    assign w_result  = w_prod[36:21];

    // operand selection, horner steps first, then scaling
    always_comb begin
        w_mul_a = 32'(r_x);
        w_mul_b = 32'(r_x);
        case (w_ctl.op)
            spwmcg_pkg::OP_SQ: begin
                w_mul_a = 32'(r_x);
                w_mul_b = 32'(r_x);
            end
            spwmcg_pkg::OP_T9: begin
                w_mul_a = w_q30;
                w_mul_b = spwmcg_pkg::COEF_A9;
            end
            spwmcg_pkg::OP_T7: begin
                w_mul_a = r_x2;
                w_mul_b = spwmcg_pkg::COEF_A7 - w_q30;
            end
            spwmcg_pkg::OP_T5: begin
                w_mul_a = r_x2;
                w_mul_b = spwmcg_pkg::COEF_A5 - w_q30;
            end
            spwmcg_pkg::OP_T3: begin
                w_mul_a = r_x2;
                w_mul_b = spwmcg_pkg::COEF_A3 - w_q30;
            end
            spwmcg_pkg::OP_T1: begin
                w_mul_a = 32'(r_x);
                w_mul_b = spwmcg_pkg::COEF_A1 - w_q30;
            end
            spwmcg_pkg::OP_DP: begin
                w_mul_a = 32'(r_depth);
                w_mul_b = 32'(r_period);
            end
            spwmcg_pkg::OP_TM: begin
                w_mul_a = w_prod[31:0];
                w_mul_b = 32'(r_term);
            end
            spwmcg_pkg::OP_DV: begin
                w_mul_a = w_div_in;
                w_mul_b = spwmcg_pkg::DIV5_RECIP;
            end
            default: begin
                w_mul_a = 32'(r_x);
                w_mul_b = 32'(r_x);
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x   <= w_x;
            r_neg <= w_idx[SINE_TABLE_BITS-1];
        end
        if (w_ctl.run && (w_ctl.op == spwmcg_pkg::OP_T9)) begin
            r_x2 <= w_q30;
        end
        if (w_ctl.run && (w_ctl.op == spwmcg_pkg::OP_DP)) begin
            r_term <= w_term;
        end
    end

    // output register
    logic        r_out_valid;
    logic [15:0] r_out_value;
    logic        r_out_target;
    logic        w_out_load;

    assign w_out_load = w_ctl.run && (w_ctl.op == spwmcg_pkg::OP_OUT) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_value  <= w_result;
            r_out_target <= r_target;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_target;

    // checks
    `SPWMCG_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, !s_axis_tready)
    `SPWMCG_ASSERT_NXT(a_tick_advances, i_clk, i_rst_n, w_in_acc && (s_axis_tuser == spwmcg_pkg::CMD_TICK), r_phase == PHASE_BITS'($past(r_phase) + $past(w_step)))
    `SPWMCG_ASSERT_IMP(a_word_from_last_step, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(w_out_load))

endmodule

`default_nettype wire

@@ hw/rtl/spwmcg_mul.sv @@
// shared 32 x 32 unsigned multiplier with registered product
// depends on nothing
`default_nettype none

module spwmcg_mul (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_prod
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 64'(i_a) * 64'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ hw/rtl/spwmcg_seq.sv @@
// sequencer that steps the shared multiplier through one item
// depends on spwmcg_pkg
`default_nettype none

module spwmcg_seq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic                i_out_free,
    output spwmcg_pkg::t_seq_ctl     o_ctl
);

    spwmcg_pkg::t_state r_state, n_state;
    spwmcg_pkg::t_op    r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spwmcg_pkg::ST_IDLE;
            r_op    <= spwmcg_pkg::OP_SQ;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // next state and step
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            spwmcg_pkg::ST_IDLE: begin
                n_op = spwmcg_pkg::OP_SQ;
                if (i_start) begin
                    n_state = spwmcg_pkg::ST_RUN;
                end
            end
            spwmcg_pkg::ST_RUN: begin
                case (r_op)
                    spwmcg_pkg::OP_SQ: n_op = spwmcg_pkg::OP_T9;
                    spwmcg_pkg::OP_T9: n_op = spwmcg_pkg::OP_T7;
                    spwmcg_pkg::OP_T7: n_op = spwmcg_pkg::OP_T5;
                    spwmcg_pkg::OP_T5: n_op = spwmcg_pkg::OP_T3;
                    spwmcg_pkg::OP_T3: n_op = spwmcg_pkg::OP_T1;
                    spwmcg_pkg::OP_T1: n_op = spwmcg_pkg::OP_DP;
                    spwmcg_pkg::OP_DP: n_op = spwmcg_pkg::OP_TM;
                    spwmcg_pkg::OP_TM: n_op = spwmcg_pkg::OP_DV;
                    spwmcg_pkg::OP_DV: n_op = spwmcg_pkg::OP_OUT;
                    spwmcg_pkg::OP_OUT: begin
                        // hold here until the output register can take the word
                        if (i_out_free) begin
                            n_op    = spwmcg_pkg::OP_SQ;
                            n_state = spwmcg_pkg::ST_IDLE;
                        end
                    end
                    default: n_op = spwmcg_pkg::OP_SQ;
                endcase
            end
            default: begin
                n_state = spwmcg_pkg::ST_IDLE;
                n_op    = spwmcg_pkg::OP_SQ;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ctl.op    = r_op;
        o_ctl.run   = 1'b0;
        o_ctl.ready = 1'b0;
        case (r_state)
            spwmcg_pkg::ST_IDLE: o_ctl.ready = 1'b1;
            spwmcg_pkg::ST_RUN:  o_ctl.run   = 1'b1;
            default: begin
                o_ctl.run   = 1'b0;
                o_ctl.ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire
